// File: rtl/kcl_pkg.sv
// Shared types, codes and widths of the keyed connection list.
package kcl_pkg;

   // Default number of entries the table can hold.
   localparam int CAPACITY_DEF = 16;

   // Field widths of the transaction payloads.
   localparam int OP_W     = 3;
   localparam int ID_W     = 16;
   localparam int ACT_W    = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ADD_FRONT    = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD_BACK     = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 3'd2;
   localparam logic [OP_W-1:0] OP_FIND         = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE       = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR        = 3'd5;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [ID_W-1:0]  conn_id;
      logic [ACT_W-1:0] action_code;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     entry_id;
      logic [ACT_W-1:0]    entry_action;
      logic [COUNT_W-1:0]  entry_count;
      logic                is_empty;
   } rsp_type;

   // Requests to the free slot pool.
   typedef struct packed {
      logic take;
      logic put;
      logic clear;
   } pool_ctl_type;

   // Write enables of the slot memories.
   typedef struct packed {
      logic data_we;
      logic link_we;
   } slot_we_type;

endpackage

// File: rtl/kcl_slots.sv
// Slot storage: id and action memory plus link memory, one shared registered read port.
module kcl_slots
   import kcl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int SLOT_W = $clog2(CAPACITY)
) (
   input  logic              clock,
   input  slot_we_type       we,
   input  logic [SLOT_W-1:0] data_addr,
   input  logic [ID_W-1:0]   wr_id,
   input  logic [ACT_W-1:0]  wr_act,
   input  logic [SLOT_W-1:0] link_addr,
   input  logic [SLOT_W-1:0] wr_link,
   input  logic [SLOT_W-1:0] rd_addr,
   output logic [ID_W-1:0]   rd_id,
   output logic [ACT_W-1:0]  rd_act,
   output logic [SLOT_W-1:0] rd_link
);

   logic [ID_W-1:0]   slot_id_ff     [CAPACITY];
   logic [ACT_W-1:0]  slot_action_ff [CAPACITY];
   logic [SLOT_W-1:0] slot_link_ff   [CAPACITY];
   logic [ID_W-1:0]   rd_id_ff;
   logic [ACT_W-1:0]  rd_act_ff;
   logic [SLOT_W-1:0] rd_link_ff;

   always_ff @(posedge clock) begin
      if (we.data_we) begin
         slot_id_ff[data_addr]     <= wr_id;
         slot_action_ff[data_addr] <= wr_act;
      end
      if (we.link_we) begin
         slot_link_ff[link_addr] <= wr_link;
      end
      rd_id_ff   <= slot_id_ff[rd_addr];
      rd_act_ff  <= slot_action_ff[rd_addr];
      rd_link_ff <= slot_link_ff[rd_addr];
   end

   assign rd_id   = rd_id_ff;
   assign rd_act  = rd_act_ff;
   assign rd_link = rd_link_ff;

endmodule

// File: rtl/kcl_pool.sv
// Free slot pool: a stack of returned slots above a high-water mark of never-used slots.
module kcl_pool
   import kcl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int SLOT_W = $clog2(CAPACITY),
   localparam int CNT_W  = $clog2(CAPACITY + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  pool_ctl_type      ctl,
   input  logic [SLOT_W-1:0] put_slot,
   output logic [SLOT_W-1:0] free_slot,
   output logic [CNT_W-1:0]  held_count
);

   logic [CNT_W-1:0]  hwm_ff, hwm_in;
   logic [CNT_W-1:0]  sp_ff, sp_in;
   logic [SLOT_W-1:0] stack_ff [CAPACITY];
   logic [SLOT_W-1:0] top_ff;
   logic [SLOT_W-1:0] top_addr;

   // The top of the stack is read every cycle; it is stable in the cycle after sp settles.
   assign top_addr = (sp_ff == '0) ? '0 : SLOT_W'(sp_ff - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (ctl.put) begin
         stack_ff[sp_ff[SLOT_W-1:0]] <= put_slot;
      end
      top_ff <= stack_ff[top_addr];
   end

   always_comb begin
      hwm_in = hwm_ff;
      sp_in  = sp_ff;
      priority if (ctl.clear) begin
         hwm_in = '0;
         sp_in  = '0;
      end else if (ctl.take) begin
         if (sp_ff != '0) begin
            sp_in = sp_ff - CNT_W'(1);
         end else begin
            hwm_in = hwm_ff + CNT_W'(1);
         end
      end else if (ctl.put) begin
         sp_in = sp_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hwm_ff <= '0;
         sp_ff  <= '0;
      end else begin
         hwm_ff <= hwm_in;
         sp_ff  <= sp_in;
      end
   end

   assign free_slot  = (sp_ff != '0) ? top_ff : hwm_ff[SLOT_W-1:0];
   assign held_count = hwm_ff - sp_ff;

   // Every slot on the stack was once handed out below the high-water mark.
   a_stack_below_hwm: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= hwm_ff)
      else $error("free stack deeper than the high-water mark");

   a_hwm_in_range: assert property (@(posedge clock) disable iff (reset)
      hwm_ff <= CNT_W'(CAPACITY))
      else $error("high-water mark beyond capacity");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      !(ctl.take && ctl.put))
      else $error("slot taken and returned in the same cycle");

endmodule

// File: rtl/keyed_connection_list.sv
// Top level of the keyed connection list: sequencer, front/back pointers and result register.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_data  (operation, conn_id, action_code)
//   rsp_      out        rsp_valid / rsp_stall  rsp_data  (status, entry_id, entry_action,
//                                                          entry_count, is_empty)
//
// Add, remove front, clear and the unused codes pass through the fetch and execute steps.
// Find and delete pass through the fetch step and then walk the list from the front until
// the match or the last entry held; on an empty table they go to the execute step instead.
// The walk reads one slot per cycle through the single read port of the slot memory.
// Reset clears the sequencer, the pointers and the free slot pool at once; no clearing pass.
// A new transaction is accepted only while the sequencer is idle, even when a result still
// waits in the output register; a stalled result holds the finishing step until it is taken.
module keyed_connection_list
   import kcl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   // Sequencer states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FETCH = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;
   localparam logic [1:0] S_WALK  = 2'd3;

   logic [1:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   logic [SLOT_W-1:0] front_ff, front_in;
   logic [SLOT_W-1:0] back_ff, back_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic [SLOT_W-1:0] prev_ff, prev_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Slot memory connections.
   slot_we_type       slot_we;
   logic [SLOT_W-1:0] data_addr;
   logic [SLOT_W-1:0] link_addr;
   logic [SLOT_W-1:0] wr_link;
   logic [SLOT_W-1:0] rd_addr;
   logic [ID_W-1:0]   rd_id;
   logic [ACT_W-1:0]  rd_act;
   logic [SLOT_W-1:0] rd_link;

   // Free slot pool connections.
   pool_ctl_type      pool_ctl;
   logic [SLOT_W-1:0] put_slot;
   logic [SLOT_W-1:0] free_slot;
   logic [CNT_W-1:0]  held_count;

   logic                      req_take;
   logic                      out_free;
   logic                      rsp_load;
   logic                      is_search;
   logic                      hit;
   logic                      last_step;
   logic [STATUS_W-1:0]       status;
   logic [ID_W-1:0]           entry_id;
   logic [ACT_W-1:0]          entry_action;
   logic [CNT_W-1:0]          count_next;
   logic [CNT_W+COUNT_W-1:0]  count_ext;

   kcl_slots #(.CAPACITY(CAPACITY)) u_slots (
      .clock     (clock),
      .we        (slot_we),
      .data_addr (data_addr),
      .wr_id     (req_ff.conn_id),
      .wr_act    (req_ff.action_code),
      .link_addr (link_addr),
      .wr_link   (wr_link),
      .rd_addr   (rd_addr),
      .rd_id     (rd_id),
      .rd_act    (rd_act),
      .rd_link   (rd_link)
   );

   kcl_pool #(.CAPACITY(CAPACITY)) u_pool (
      .clock      (clock),
      .reset      (reset),
      .ctl        (pool_ctl),
      .put_slot   (put_slot),
      .free_slot  (free_slot),
      .held_count (held_count)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   // The result register can take a new result when empty or when its result leaves now.
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign is_search = (req_ff.operation == OP_FIND) || (req_ff.operation == OP_DELETE);
   assign hit       = (rd_id == req_ff.conn_id);
   assign last_step = (CNT_W'(step_ff + CNT_W'(1)) == held_count);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      step_in      = step_ff;
      slot_we      = '0;
      data_addr    = free_slot;
      link_addr    = free_slot;
      wr_link      = front_ff;
      rd_addr      = front_ff;
      pool_ctl     = '0;
      put_slot     = front_ff;
      rsp_load     = 1'b0;
      status       = ST_OK;
      entry_id     = '0;
      entry_action = '0;
      count_next   = held_count;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               req_in   = req_data;
               state_in = S_FETCH;
            end
         end

         // Slot and pool reads are issued here; their data is ready in the next state.
         S_FETCH: begin
            cur_in  = front_ff;
            prev_in = front_ff;
            step_in = '0;
            if (is_search && (held_count != '0)) begin
               state_in = S_WALK;
            end else begin
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               unique case (req_ff.operation)
                  OP_ADD_FRONT, OP_ADD_BACK: begin
                     if (held_count == CNT_W'(CAPACITY)) begin
                        status = ST_FULL;
                     end else begin
                        slot_we.data_we = 1'b1;
                        pool_ctl.take   = 1'b1;
                        count_next      = held_count + CNT_W'(1);
                        if (held_count == '0) begin
                           front_in = free_slot;
                           back_in  = free_slot;
                        end else if (req_ff.operation == OP_ADD_FRONT) begin
                           // The new entry points at the old front.
                           slot_we.link_we = 1'b1;
                           link_addr       = free_slot;
                           wr_link         = front_ff;
                           front_in        = free_slot;
                        end else begin
                           // The old back entry points at the new one.
                           slot_we.link_we = 1'b1;
                           link_addr       = back_ff;
                           wr_link         = free_slot;
                           back_in         = free_slot;
                        end
                     end
                  end
                  OP_REMOVE_FRONT: begin
                     if (held_count == '0) begin
                        status = ST_EMPTY;
                     end else begin
                        entry_id     = rd_id;
                        entry_action = rd_act;
                        front_in     = rd_link;
                        pool_ctl.put = 1'b1;
                        put_slot     = front_ff;
                        count_next   = held_count - CNT_W'(1);
                        if (held_count == CNT_W'(1)) begin
                           front_in = '0;
                           back_in  = '0;
                        end
                     end
                  end
                  OP_FIND, OP_DELETE: begin
                     // Only an empty table reaches this point.
                     status = ST_NOT_FOUND;
                  end
                  OP_CLEAR: begin
                     pool_ctl.clear = 1'b1;
                     front_in       = '0;
                     back_in        = '0;
                     count_next     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // One entry is compared per cycle; a match or the last entry waits for a free result register.
         S_WALK: begin
            rd_addr = cur_ff;
            priority if (hit) begin
               if (out_free) begin
                  rsp_load     = 1'b1;
                  state_in     = S_IDLE;
                  entry_id     = rd_id;
                  entry_action = rd_act;
                  if (req_ff.operation == OP_DELETE) begin
                     pool_ctl.put = 1'b1;
                     put_slot     = cur_ff;
                     count_next   = held_count - CNT_W'(1);
                     if (step_ff == '0) begin
                        front_in = rd_link;
                     end else begin
                        // Unlink by pointing the previous entry past the match.
                        slot_we.link_we = 1'b1;
                        link_addr       = prev_ff;
                        wr_link         = rd_link;
                     end
                     if (cur_ff == back_ff) begin
                        back_in = prev_ff;
                     end
                     if (held_count == CNT_W'(1)) begin
                        front_in = '0;
                        back_in  = '0;
                     end
                  end
               end
            end else if (last_step) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = S_IDLE;
                  status   = ST_NOT_FOUND;
               end
            end else begin
               rd_addr = rd_link;
               cur_in  = rd_link;
               prev_in = cur_ff;
               step_in = step_ff + CNT_W'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The count field is the low bits of the number of entries held.
   assign count_ext = {{COUNT_W{1'b0}}, count_next};

   always_comb begin
      rsp_in.status       = status;
      rsp_in.entry_id     = entry_id;
      rsp_in.entry_action = entry_action;
      rsp_in.entry_count  = count_ext[COUNT_W-1:0];
      rsp_in.is_empty     = (count_next == '0);
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      step_ff <= step_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An accepted transaction always starts with the read fetch step.
   a_accept_fetch: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_FETCH))
      else $error("accepted transaction did not enter the fetch step");

   // The walk never runs past the entries held.
   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (step_ff < held_count))
      else $error("walk ran past the last entry");

   // An empty table has both pointers back at slot zero.
   a_empty_pointers: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && (held_count == '0)) |-> ((front_ff == '0) && (back_ff == '0)))
      else $error("empty table with a stale front or back pointer");

endmodule
